[hw/rtl/pcgnms_pkg.sv]
package pcgnms_pkg;

    localparam int MaxDetections = 64;
    localparam logic [15:0] ThrReset = 16'd13959;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEL_INIT,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_CHK_INIT,
        ST_CHK_RD,
        ST_CHK_MUL,
        ST_CHK_CMP,
        ST_EMIT_RD,
        ST_EMIT,
        ST_NONE
    } t_state;

    typedef struct packed {
        logic load_we;
        logic sel_init;
        logic sel_step;
        logic chk_init;
        logic chk_step;
        logic mul_go;
        logic cmp_go;
        logic mark_kept;
        logic rd_best;
        logic emit_load;
        logic none_load;
        logic clear_set;
    } t_cmd;

    typedef struct packed {
        logic sel_done;
        logic sel_found;
        logic chk_done;
        logic chk_hit;
        logic set_empty;
    } t_sts;

endpackage

[hw/rtl/pcgnms_ram.sv]
module pcgnms_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/pcgnms_dp.sv]
module pcgnms_dp import pcgnms_pkg::*; #(
    parameter int MaxDet = MaxDetections
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid_req,
    input  logic [6:0]  i_class_id,
    input  logic [12:0] i_box_left,
    input  logic [12:0] i_box_top,
    input  logic [12:0] i_box_width,
    input  logic [12:0] i_box_height,
    input  logic [15:0] i_confidence,
    output logic [6:0]  o_out_class,
    output logic [12:0] o_out_left,
    output logic [12:0] o_out_top,
    output logic [12:0] o_out_width,
    output logic [12:0] o_out_height,
    output logic [15:0] o_out_score,
    output logic        o_none_kept,
    output logic        o_overflowed
);
    localparam int Aw = $clog2(MaxDet);
    localparam int Cw = $clog2(MaxDet + 1);

    logic [15:0]     r_thr;
    logic [Cw-1:0]   r_count;
    logic            r_ovf;
    logic [MaxDet-1:0] r_kept;
    logic [MaxDet-1:0] r_done;
    logic [Cw-1:0]   r_idx;
    logic [Aw-1:0]   r_best;
    logic            r_found;
    logic [22:0]     r_best_cs;
    logic [51:0]     r_cand_box;
    logic [Aw-1:0]   r_rd_idx;
    logic            r_hit;
    logic [27:0]     r_inter;
    logic [27:0]     r_area_a;
    logic [27:0]     r_area_b;
    logic [43:0]     r_lhs;
    logic [44:0]     r_rhs;
    logic            r_pair_ok;
    logic [51:0]     box_rd;
    logic [22:0]     cs_rd;
    logic [Aw-1:0]   raddr;
    logic            full;

    assign full = (r_count == Cw'(MaxDet));
    assign raddr = i_cmd.rd_best ? r_best : r_idx[Aw-1:0];

    pcgnms_ram #(.Width(52), .Depth(MaxDet)) u_box (
        .i_clk(i_clk), .i_we(i_cmd.load_we && i_valid_req && !full),
        .i_waddr(r_count[Aw-1:0]),
        .i_wdata({i_box_height, i_box_width, i_box_top, i_box_left}),
        .i_raddr(raddr), .o_rdata(box_rd));

    pcgnms_ram #(.Width(23), .Depth(MaxDet)) u_cs (
        .i_clk(i_clk), .i_we(i_cmd.load_we && i_valid_req && !full),
        .i_waddr(r_count[Aw-1:0]),
        .i_wdata({i_confidence, i_class_id}),
        .i_raddr(raddr), .o_rdata(cs_rd));

    // box pair geometry
    logic [13:0] la, ta, ra, ba, lb, tb, rb, bb, l, t, r, b, iw, ih;
    always_comb begin
        la = {1'b0, r_cand_box[12:0]};
        ta = {1'b0, r_cand_box[25:13]};
        ra = la + {1'b0, r_cand_box[38:26]};
        ba = ta + {1'b0, r_cand_box[51:39]};
        lb = {1'b0, box_rd[12:0]};
        tb = {1'b0, box_rd[25:13]};
        rb = lb + {1'b0, box_rd[38:26]};
        bb = tb + {1'b0, box_rd[51:39]};
        l = (la > lb) ? la : lb;
        t = (ta > tb) ? ta : tb;
        r = (ra < rb) ? ra : rb;
        b = (ba < bb) ? ba : bb;
        iw = (r > l) ? r - l : 14'd0;
        ih = (b > t) ? b - t : 14'd0;
    end

    logic [28:0] uni;
    assign uni = {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};

    logic sel_better, chk_cand;
    always_comb begin
        sel_better = 1'b0;
        if (!r_done[r_rd_idx]) begin
            if (!r_found) begin
                sel_better = 1'b1;
            end else if (cs_rd[6:0] != r_best_cs[6:0]) begin
                sel_better = cs_rd[6:0] < r_best_cs[6:0];
            end else begin
                sel_better = cs_rd[22:7] > r_best_cs[22:7];
            end
        end
        chk_cand = r_kept[r_rd_idx] && (cs_rd[6:0] == r_best_cs[6:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= ThrReset;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_kept  <= '0;
            r_done  <= '0;
            r_hit   <= 1'b0;
            r_pair_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.load_we && i_valid_req) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.sel_init) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.sel_step) begin
                r_rd_idx <= r_idx[Aw-1:0];
                r_idx    <= r_idx + 1'b1;
            end
            if (i_cmd.cmp_go && !i_cmd.chk_step && !i_cmd.mul_go) begin
                if (sel_better) begin
                    r_found   <= 1'b1;
                    r_best    <= r_rd_idx;
                    r_best_cs <= cs_rd;
                end
            end
            if (i_cmd.chk_init) begin
                r_idx <= '0;
                r_hit <= 1'b0;
                r_cand_box <= box_rd;
                r_done[r_best] <= 1'b1;
            end
            if (i_cmd.chk_step && !i_cmd.cmp_go) begin
                r_rd_idx <= r_idx[Aw-1:0];
                r_idx    <= r_idx + 1'b1;
            end
            if (i_cmd.mul_go && !i_cmd.cmp_go) begin
                r_inter   <= iw * ih;
                r_area_a  <= r_cand_box[38:26] * r_cand_box[51:39];
                r_area_b  <= box_rd[38:26] * box_rd[51:39];
                r_pair_ok <= chk_cand;
            end
            if (i_cmd.cmp_go && i_cmd.chk_step) begin
                r_lhs <= {r_inter, 16'd0};
                r_rhs <= 45'(r_thr * uni);
            end
            if (i_cmd.cmp_go && i_cmd.mul_go) begin
                if (r_pair_ok && uni != 29'd0 && {1'b0, r_lhs} >= r_rhs) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.mark_kept) begin
                r_kept[r_best] <= 1'b1;
            end
            if (i_cmd.clear_set) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_kept  <= '0;
                r_done  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load || i_cmd.none_load) begin
            o_out_class  <= i_cmd.none_load ? 7'd0 : cs_rd[6:0];
            o_out_left   <= i_cmd.none_load ? 13'd0 : box_rd[12:0];
            o_out_top    <= i_cmd.none_load ? 13'd0 : box_rd[25:13];
            o_out_width  <= i_cmd.none_load ? 13'd0 : box_rd[38:26];
            o_out_height <= i_cmd.none_load ? 13'd0 : box_rd[51:39];
            o_out_score  <= i_cmd.none_load ? 16'd0 : cs_rd[22:7];
            o_none_kept  <= i_cmd.none_load;
            o_overflowed <= r_ovf;
        end
    end

    assign o_sts.sel_done  = (r_idx == r_count);
    assign o_sts.sel_found = r_found;
    assign o_sts.chk_done  = (r_idx == r_count);
    assign o_sts.chk_hit   = r_hit || (r_thr == 16'd0);
    assign o_sts.set_empty = (r_kept == '0);
endmodule

[hw/rtl/pcgnms_ctrl.sv]
module pcgnms_ctrl import pcgnms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_xfer,
    input  logic i_set_end,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_last_result
);
    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_last, n_last;
    logic   r_pend, n_pend;
    logic [1:0] r_pipe, n_pipe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_pend  <= 1'b0;
            r_pipe  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_pipe  <= n_pipe;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_last  = r_last;
        n_pend  = r_pend;
        n_pipe  = r_pipe;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            ST_LOAD: begin
                o_in_ready = !r_valid;
                if (i_in_xfer) begin
                    o_cmd.load_we = 1'b1;
                    if (i_set_end) begin
                        n_state = ST_SEL_INIT;
                    end
                end
            end
            ST_SEL_INIT: begin
                o_cmd.sel_init = 1'b1;
                n_state = ST_SEL_RD;
            end
            // each entry in turn: read, then compare
            ST_SEL_RD: begin
                if (i_sts.sel_done) begin
                    n_state = i_sts.sel_found ? ST_CHK_INIT : ST_NONE;
                end else begin
                    o_cmd.sel_step = 1'b1;
                    n_state = ST_SEL_CMP;
                end
            end
            ST_SEL_CMP: begin
                o_cmd.cmp_go = 1'b1;
                n_state = ST_SEL_RD;
            end
            ST_CHK_INIT: begin
                o_cmd.rd_best = 1'b1;
                n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                o_cmd.chk_init = 1'b1;
                n_state = ST_CHK_RD;
            end
            ST_CHK_RD: begin
                if (i_sts.chk_done) begin
                    if (i_sts.chk_hit) begin
                        n_state = ST_SEL_INIT;
                    end else if (r_pend) begin
                        // another box follows, so the held one is not the last
                        n_valid = 1'b1;
                        n_last  = 1'b0;
                        n_pend  = 1'b0;
                    end else if (!r_valid || i_out_ready) begin
                        o_cmd.mark_kept = 1'b1;
                        o_cmd.rd_best = 1'b1;
                        n_state = ST_EMIT;
                    end
                end else begin
                    o_cmd.chk_step = 1'b1;
                    n_state = ST_CHK_MUL;
                end
            end
            ST_CHK_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = ST_CHK_CMP;
                n_pipe = 2'd0;
            end
            ST_CHK_CMP: begin
                o_cmd.cmp_go = 1'b1;
                if (r_pipe == 2'd0) begin
                    o_cmd.chk_step = 1'b1;
                    o_cmd.sel_step = 1'b0;
                    n_pipe = 2'd1;
                end else begin
                    o_cmd.mul_go = 1'b1;
                    n_state = ST_CHK_RD;
                end
            end
            ST_EMIT: begin
                o_cmd.emit_load = 1'b1;
                n_pend  = 1'b1;
                n_state = ST_SEL_INIT;
            end
            ST_NONE: begin
                if (!r_valid || i_out_ready) begin
                    if (i_sts.set_empty) begin
                        o_cmd.none_load = 1'b1;
                    end
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    n_pend  = 1'b0;
                    o_cmd.clear_set = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_out_valid   = r_valid;
    assign o_last_result = r_last;
endmodule

[hw/rtl/per_class_greedy_nms.sv]
// per-class greedy non-maximum suppression
// input channel: one detection per transfer (valid_req=0 stores nothing);
//   set_end=1 closes the set and starts suppression
// up to MAX_DETECTIONS detections are stored; extra ones are dropped and the
//   overflowed flag is raised on every result of that set
// suppression picks the next candidate by a scan of all stored entries
//   and then checks it for overlap against every kept entry of its class,
//   using a per-entry read, multiply and compare sequence
// results: kept boxes in ascending class, then descending confidence;
//   last_result marks the final one; a set with no kept box gives one
//   none_kept result
// note: each kept box is held until the next kept box is found or the set
//   scan ends, so it leaves only once it is known whether it is the last
// input is not taken while a result waits or while a set is processed
// receiver stalls simply hold the output register and pause the sequencer
// reset clears all control state and loads the default threshold 13959
// the threshold register may be written only while the block is idle
module per_class_greedy_nms import pcgnms_pkg::*; #(
    parameter int MAX_DETECTIONS = MaxDetections
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_valid_req,
    input  logic [6:0]  i_class_id,
    input  logic [12:0] i_box_left,
    input  logic [12:0] i_box_top,
    input  logic [12:0] i_box_width,
    input  logic [12:0] i_box_height,
    input  logic [15:0] i_confidence,
    input  logic        i_set_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_out_class,
    output logic [12:0] o_out_left,
    output logic [12:0] o_out_top,
    output logic [12:0] o_out_width,
    output logic [12:0] o_out_height,
    output logic [15:0] o_out_score,
    output logic        o_none_kept,
    output logic        o_overflowed,
    output logic        o_last_result
);
    t_cmd cmd;
    t_sts sts;

    pcgnms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_xfer(i_in_valid && o_in_ready), .i_set_end(i_set_end),
        .i_out_ready(i_out_ready), .i_sts(sts), .o_cmd(cmd),
        .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
        .o_last_result(o_last_result));

    pcgnms_dp #(.MaxDet(MAX_DETECTIONS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid_req(i_valid_req), .i_class_id(i_class_id),
        .i_box_left(i_box_left), .i_box_top(i_box_top),
        .i_box_width(i_box_width), .i_box_height(i_box_height),
        .i_confidence(i_confidence),
        .o_out_class(o_out_class), .o_out_left(o_out_left),
        .o_out_top(o_out_top), .o_out_width(o_out_width),
        .o_out_height(o_out_height), .o_out_score(o_out_score),
        .o_none_kept(o_none_kept), .o_overflowed(o_overflowed));
endmodule

[hw/rtl/pcgnms_chk.sv]
module pcgnms_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_out_score,
    input logic        o_none_kept,
    input logic        o_last_result
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_score))
        else $error("output changed under stall");
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_kept |-> o_last_result)
        else $error("none_kept without last_result");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_kept |-> o_out_score == 16'd0)
        else $error("none_kept with score");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while result waits");
endmodule

bind per_class_greedy_nms pcgnms_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_out_score(o_out_score), .o_none_kept(o_none_kept),
    .o_last_result(o_last_result));

[dv/per_class_greedy_nms_test.sv]
module per_class_greedy_nms_test;
    import pcgnms_pkg::*;

    typedef struct packed {
        logic [6:0]  cls;
        logic [12:0] left;
        logic [12:0] top;
        logic [12:0] width;
        logic [12:0] height;
        logic [15:0] score;
    } t_det;

    typedef struct packed {
        t_det d;
        logic none;
        logic ovf;
        logic last;
    } t_kept;

    localparam int DetW = $bits(t_det);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_valid_req;
    logic [6:0]  i_class_id;
    logic [12:0] i_box_left;
    logic [12:0] i_box_top;
    logic [12:0] i_box_width;
    logic [12:0] i_box_height;
    logic [15:0] i_confidence;
    logic        i_set_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [6:0]  o_out_class;
    logic [12:0] o_out_left;
    logic [12:0] o_out_top;
    logic [12:0] o_out_width;
    logic [12:0] o_out_height;
    logic [15:0] o_out_score;
    logic        o_none_kept;
    logic        o_overflowed;
    logic        o_last_result;

    per_class_greedy_nms i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_valid_req(i_valid_req), .i_class_id(i_class_id),
        .i_box_left(i_box_left), .i_box_top(i_box_top),
        .i_box_width(i_box_width), .i_box_height(i_box_height),
        .i_confidence(i_confidence), .i_set_end(i_set_end),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_class(o_out_class), .o_out_left(o_out_left),
        .o_out_top(o_out_top), .o_out_width(o_out_width),
        .o_out_height(o_out_height), .o_out_score(o_out_score),
        .o_none_kept(o_none_kept), .o_overflowed(o_overflowed),
        .o_last_result(o_last_result)
    );

    t_det        set_dets[$];
    logic        set_ovf;
    logic [15:0] iou_thr;
    t_kept       kept_expected[$];
    int          errors;
    int          items_sent;
    int          sets_closed;
    int          results_seen;
    bit          in_idle_on;
    bit          out_idle_on;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 3000000);
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    function automatic bit overlapping(t_det a, t_det b);
        longint unsigned l, t, r, btm, iw, ih, inter, uni;
        l   = (a.left > b.left) ? a.left : b.left;
        t   = (a.top > b.top) ? a.top : b.top;
        r   = ((a.left + 64'(a.width)) < (b.left + 64'(b.width))) ?
              (a.left + 64'(a.width)) : (b.left + 64'(b.width));
        btm = ((a.top + 64'(a.height)) < (b.top + 64'(b.height))) ?
              (a.top + 64'(a.height)) : (b.top + 64'(b.height));
        iw  = (r > l) ? r - l : 0;
        ih  = (btm > t) ? btm - t : 0;
        inter = iw * ih;
        uni = 64'(a.width) * a.height + 64'(b.width) * b.height - inter;
        if (uni == 0)
            return 1'b0;
        return inter * 65536 >= 64'(iou_thr) * uni;
    endfunction

    function automatic bit goes_first(int a, int b);
        if (set_dets[a].cls != set_dets[b].cls)
            return set_dets[a].cls < set_dets[b].cls;
        if (set_dets[a].score != set_dets[b].score)
            return set_dets[a].score > set_dets[b].score;
        return a < b;
    endfunction

    // greedy suppression of the stored set, results appended in output order
    task automatic nms_predict();
        int    order[$];
        t_det  kept[$];
        int    j;
        bit    keep;
        t_kept k;
        for (int i = 0; i < set_dets.size(); i++) begin
            j = 0;
            while (j < order.size() && !goes_first(i, order[j]))
                j++;
            order.insert(j, i);
        end
        foreach (order[i]) begin
            keep = (iou_thr != 0);
            foreach (kept[m])
                if (keep && kept[m].cls == set_dets[order[i]].cls &&
                    overlapping(kept[m], set_dets[order[i]]))
                    keep = 1'b0;
            if (keep) begin
                kept.insert(kept.size(), set_dets[order[i]]);
                k = '0;
                k.d = set_dets[order[i]];
                k.ovf = set_ovf;
                k.last = 1'b0;
                kept_expected.insert(kept_expected.size(), k);
            end
        end
        if (kept.size() == 0) begin
            k = '0;
            k.none = 1'b1;
            k.ovf = set_ovf;
            kept_expected.insert(kept_expected.size(), k);
        end
        kept_expected[kept_expected.size() - 1].last = 1'b1;
        set_dets.delete();
        set_ovf = 1'b0;
        sets_closed++;
    endtask

    task automatic send_item(bit vreq, t_det d, bit send_end);
        if (in_idle_on) begin
            while ($urandom_range(99) < 22) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_valid_req  <= vreq;
        i_class_id   <= d.cls;
        i_box_left   <= d.left;
        i_box_top    <= d.top;
        i_box_width  <= d.width;
        i_box_height <= d.height;
        i_confidence <= d.score;
        i_set_end    <= send_end;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (vreq) begin
            if (set_dets.size() < MaxDetections)
                set_dets.insert(set_dets.size(), d);
            else
                set_ovf = 1'b1;
        end
        if (send_end)
            nms_predict();
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (kept_expected.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [15:0] thr);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        iou_thr = thr;
    endtask

    function automatic t_det rand_det();
        t_det d;
        d = DetW'({$urandom, $urandom, $urandom});
        return d;
    endfunction

    // box near a base box so that overlaps actually happen
    function automatic t_det near_det(t_det base, int spread);
        t_det d;
        d = base;
        d.left   = 13'(base.left + $urandom_range(0, spread));
        d.top    = 13'(base.top + $urandom_range(0, spread));
        d.width  = 13'(base.width + $urandom_range(0, spread));
        d.height = 13'(base.height + $urandom_range(0, spread));
        d.score  = ($urandom_range(3) == 0) ? base.score : 16'($urandom);
        return d;
    endfunction

    function automatic t_det mk(int c, int l, int t, int w, int h, int s);
        t_det d;
        d.cls = 7'(c); d.left = 13'(l); d.top = 13'(t);
        d.width = 13'(w); d.height = 13'(h); d.score = 16'(s);
        return d;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (kept_expected.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                t_kept e;
                e = kept_expected.pop_front();
                if (o_out_class != e.d.cls)      report("class", o_out_class, e.d.cls);
                if (o_out_left != e.d.left)      report("left", o_out_left, e.d.left);
                if (o_out_top != e.d.top)        report("top", o_out_top, e.d.top);
                if (o_out_width != e.d.width)    report("width", o_out_width, e.d.width);
                if (o_out_height != e.d.height)  report("height", o_out_height, e.d.height);
                if (o_out_score != e.d.score)    report("score", o_out_score, e.d.score);
                if (o_none_kept != e.none)       report("none_kept", o_none_kept, e.none);
                if (o_overflowed != e.ovf)       report("overflowed", o_overflowed, e.ovf);
                if (o_last_result != e.last)     report("last_result", o_last_result, e.last);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(out_idle_on && $urandom_range(99) < 22);
        end
    end

    task automatic test_directed();
        send_item(1'b0, rand_det(), 1'b1);
        send_item(1'b1, mk(0, 0, 0, 0, 0, 0), 1'b0);
        send_item(1'b1, mk(0, 0, 0, 0, 0, 100), 1'b0);
        send_item(1'b1, mk(127, 8191, 8191, 8191, 8191, 65535), 1'b0);
        send_item(1'b1, mk(127, 8191, 8191, 8191, 8191, 65535), 1'b0);
        send_item(1'b1, mk(5, 100, 100, 100, 100, 500), 1'b0);
        send_item(1'b1, mk(5, 110, 100, 100, 100, 500), 1'b0);
        send_item(1'b1, mk(5, 300, 300, 10, 10, 700), 1'b0);
        send_item(1'b1, mk(6, 100, 100, 100, 100, 500), 1'b0);
        send_item(1'b0, mk(9, 1, 1, 1, 1, 1), 1'b0);
        send_item(1'b1, mk(3, 0, 0, 100, 100, 900), 1'b1);
        // exact threshold: iou of one half against 32768
        set_threshold(16'd32768);
        send_item(1'b1, mk(1, 0, 0, 100, 100, 10), 1'b0);
        send_item(1'b1, mk(1, 0, 0, 100, 50, 20), 1'b1);
        set_threshold(16'd32769);
        send_item(1'b1, mk(1, 0, 0, 100, 100, 10), 1'b0);
        send_item(1'b1, mk(1, 0, 0, 100, 50, 20), 1'b1);
        set_threshold(16'd0);
        send_item(1'b1, mk(2, 10, 10, 5, 5, 1), 1'b0);
        send_item(1'b1, mk(4, 90, 10, 5, 5, 2), 1'b1);
        set_threshold(16'd65535);
        send_item(1'b1, mk(2, 10, 10, 5, 5, 1), 1'b0);
        send_item(1'b1, mk(2, 10, 10, 5, 5, 1), 1'b0);
        send_item(1'b1, mk(2, 10, 10, 5, 6, 3), 1'b1);
    endtask

    task automatic test_overflow();
        t_det base;
        set_threshold(16'd13959);
        base = rand_det();
        for (int i = 0; i < MaxDetections + 2; i++)
            send_item(1'b1, ($urandom_range(1) != 0) ? near_det(base, 40) : rand_det(),
                      i == MaxDetections + 1);
    endtask

    task automatic test_backpressure();
        t_det base;
        wait_drain();
        hold_cycles = 1500;
        for (int s = 0; s < 3; s++) begin
            base = rand_det();
            for (int i = 0; i < 3; i++)
                send_item(1'b1, near_det(base, 8), i == 2);
        end
    endtask

    task automatic test_random();
        t_det base;
        int   n;
        for (int s = 0; s < 15; s++) begin
            if (s % 4 == 3)
                set_threshold((s == 7) ? 16'd1 : (s == 11) ? 16'd65535 : 16'($urandom));
            in_idle_on  = (s < 8 || s > 13);
            out_idle_on = in_idle_on;
            n = ($urandom_range(7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
            base = rand_det();
            base.cls = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 2));
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0)
                    send_item(1'b0, rand_det(), 1'b0);
                send_item(1'b1, ($urandom_range(4) == 0) ? rand_det() :
                          near_det(base, $urandom_range(0, 1) ? 4 : 60), 1'b0);
            end
            send_item(1'($urandom_range(1)), near_det(base, 20), 1'b1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_valid_req = 1'b0;
        i_class_id = '0;
        i_box_left = '0;
        i_box_top = '0;
        i_box_width = '0;
        i_box_height = '0;
        i_confidence = '0;
        i_set_end = 1'b0;
        i_out_ready = 1'b0;
        iou_thr = ThrReset;
        set_ovf = 1'b0;
        errors = 0;
        items_sent = 0;
        sets_closed = 0;
        results_seen = 0;
        hold_cycles = 0;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        wait_drain();
        $display("%0d transfers in %0d sets, %0d results checked", items_sent,
                 sets_closed, results_seen);
        $display("covered ties, zero areas, overflow, threshold extremes, long stall");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
